[src/qrs_pkg.sv]
// Package for the quadratic root solver: field widths, solution kind codes and
// the sideband structs that travel next to the square root and divider cells.
// No dependencies.
package qrs_pkg;

  localparam int COEF_W = 16;
  localparam int ROOT_W = 32;
  localparam int DISC_W = 35;
  localparam int RAD_W = 64;
  localparam int SQRT_STEPS = 32;
  localparam int REM_W = 34;
  localparam int NUM_W = 34;
  localparam int DIV_STEPS = NUM_W;
  localparam int DVR_W = 16;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_NONE = 2'd0;
  localparam kind_t KIND_SINGLE = 2'd1;
  localparam kind_t KIND_TWO = 2'd2;
  localparam kind_t KIND_UNLIMITED = 2'd3;

  // Item state while the square root runs.
  typedef struct packed {
    logic valid;
    kind_t kind;
    logic div_en;
    logic use_s;
    logic signed [32:0] nbase;
    logic signed [COEF_W-1:0] dv;
  } sq_side_t;

  // Item state while the two quotients are formed.
  typedef struct packed {
    logic valid;
    kind_t kind;
    logic div_en;
    logic neg1;
    logic neg2;
    logic [DVR_W-1:0] dmag;
  } dv_side_t;

  typedef struct packed {
    kind_t kind;
    logic signed [ROOT_W-1:0] r1;
    logic signed [ROOT_W-1:0] r2;
    logic sat;
  } res_t;

endpackage

[src/qrs_coef_if.sv]
// Channel interface carrying one coefficient set per item.
// Depends on qrs_pkg for the coefficient width.
interface qrs_coef_if;
  import qrs_pkg::*;
  logic valid;
  logic ready;
  logic signed [COEF_W-1:0] coef_quad;
  logic signed [COEF_W-1:0] coef_lin;
  logic signed [COEF_W-1:0] coef_const;
  modport source (output valid, coef_quad, coef_lin, coef_const, input ready);
  modport sink (input valid, coef_quad, coef_lin, coef_const, output ready);
endinterface

[src/qrs_result_if.sv]
// Channel interface carrying one classified solution per item.
// Depends on qrs_pkg for the root width.
interface qrs_result_if;
  import qrs_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] solution_kind;
  logic signed [ROOT_W-1:0] root_one;
  logic signed [ROOT_W-1:0] root_two;
  logic saturated;
  modport source (output valid, solution_kind, root_one, root_two, saturated, input ready);
  modport sink (input valid, solution_kind, root_one, root_two, saturated, output ready);
endinterface

[src/qrs_sqrt_cell.sv]
// One digit step of the integer square root: consumes two radicand bits and
// produces one root bit. Depends on qrs_pkg.
module qrs_sqrt_cell (
  input  logic clk,
  input  logic en,
  input  logic [qrs_pkg::RAD_W-1:0] rad_i,
  input  logic [qrs_pkg::REM_W-1:0] rem_i,
  input  logic [qrs_pkg::ROOT_W-1:0] root_i,
  output logic [qrs_pkg::RAD_W-1:0] rad_o,
  output logic [qrs_pkg::REM_W-1:0] rem_o,
  output logic [qrs_pkg::ROOT_W-1:0] root_o
);
  import qrs_pkg::*;

  logic [REM_W+1:0] sh;
  logic [REM_W+1:0] trial;
  logic [REM_W+1:0] rem_n;
  logic ge;

  always_comb begin
    sh = {rem_i, rad_i[RAD_W-1 -: 2]};
    trial = {2'b00, root_i, 2'b01};
    ge = (sh >= trial);
    rem_n = ge ? (sh - trial) : sh;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_o <= {rad_i[RAD_W-3:0], 2'b00};
      rem_o <= rem_n[REM_W-1:0];
      root_o <= {root_i[ROOT_W-2:0], ge};
    end
  end
endmodule

[src/qrs_div_cell.sv]
// One restoring division step: shifts one numerator bit out into the remainder and
// shifts one quotient bit into the same register. Depends on qrs_pkg.
module qrs_div_cell (
  input  logic clk,
  input  logic en,
  input  logic [qrs_pkg::DVR_W-1:0] dmag,
  input  logic [qrs_pkg::DVR_W-1:0] rem_i,
  input  logic [qrs_pkg::NUM_W-1:0] nq_i,
  output logic [qrs_pkg::DVR_W-1:0] rem_o,
  output logic [qrs_pkg::NUM_W-1:0] nq_o
);
  import qrs_pkg::*;

  logic [DVR_W:0] sh;
  logic [DVR_W:0] diff;
  logic ge;

  always_comb begin
    sh = {rem_i, nq_i[NUM_W-1]};
    ge = (sh >= {1'b0, dmag});
    diff = sh - {1'b0, dmag};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o <= ge ? diff[DVR_W-1:0] : sh[DVR_W-1:0];
      nq_o <= {nq_i[NUM_W-2:0], ge};
    end
  end
endmodule

[src/quadratic_root_solver_unit.sv]
// Quadratic root solver top level: front stages, a row of square root cells,
// a row of divider cells and the output register with skid. Depends on qrs_pkg,
// qrs_coef_if, qrs_result_if, qrs_sqrt_cell and qrs_div_cell.
//
// Usage: each item on the coef channel is one set of signed coefficients a, b
// and c of a*x^2 + b*x + c = 0. Each item yields exactly one item on the result
// channel with the solution kind, two signed Q16.16 roots and a flag that is set
// when a root was clamped to the Q16.16 range. Items leave in arrival order.
// Throughput is one item per clock while the receiver does not stall. From
// acceptance to the result appearing on the output register, an item passes
// three front stages (input, products, discriminant and classification), 32
// square root cells, one merge stage, 34 divider cells and the output register.
// The whole pipeline advances together. When the receiver stalls, one more
// result is caught in a skid register, and coef.ready then drops (it comes
// straight from a flop) until the skid drains. Reset is synchronous and clears
// every valid bit; no result is shown after reset until an item has passed.
module quadratic_root_solver_unit (
  input  logic clk,
  input  logic rst,
  qrs_coef_if.sink coef,
  qrs_result_if.source result
);
  import qrs_pkg::*;

  logic en;
  logic skid_valid;
  logic out_valid;
  res_t skid;
  res_t out_r;

  assign en = !skid_valid;
  assign coef.ready = en;

  // Front stages.
  logic s0_valid;
  logic signed [COEF_W-1:0] s0_a, s0_b, s0_c;
  logic s1_valid;
  logic signed [COEF_W-1:0] s1_a, s1_b, s1_c;
  logic signed [31:0] s1_bb, s1_ac;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= coef.valid;
      s1_valid <= s0_valid;
    end
    if (en) begin
      s0_a <= coef.coef_quad;
      s0_b <= coef.coef_lin;
      s0_c <= coef.coef_const;
      s1_a <= s0_a;
      s1_b <= s0_b;
      s1_c <= s0_c;
      s1_bb <= s0_b * s0_b;
      s1_ac <= s0_a * s0_c;
    end
  end

  // Discriminant and case selection. Every root is a ratio of coefficients,
  // so the fixed point scale cancels: quadratic roots are
  // (32768*(-b) +/- sqrt(D * 2^30)) / a and the linear root is 65536*(-c) / b.
  logic signed [DISC_W-1:0] disc;
  sq_side_t cls;
  logic [RAD_W-1:0] cls_rad;

  always_comb begin
    disc = DISC_W'(s1_bb) - (DISC_W'(s1_ac) <<< 2);
    cls.valid = s1_valid;
    cls.kind = KIND_NONE;
    cls.div_en = 1'b0;
    cls.use_s = 1'b0;
    cls.nbase = -(33'(s1_b) <<< 15);
    cls.dv = s1_a;
    cls_rad = '0;
    if (s1_a == '0) begin
      cls.dv = s1_b;
      cls.nbase = -(33'(s1_c) <<< 16);
      if (s1_b == '0) begin
        cls.kind = (s1_c == '0) ? KIND_UNLIMITED : KIND_NONE;
      end else begin
        cls.kind = KIND_SINGLE;
        cls.div_en = 1'b1;
      end
    end else if (disc == '0) begin
      cls.kind = KIND_SINGLE;
      cls.div_en = 1'b1;
    end else if (!disc[DISC_W-1]) begin
      cls.kind = KIND_TWO;
      cls.div_en = 1'b1;
      cls.use_s = 1'b1;
      cls_rad = {1'b0, disc[32:0], 30'b0};
    end
  end

  // Square root row.
  sq_side_t sq_line [0:SQRT_STEPS];
  logic [RAD_W-1:0] st2_rad;
  logic [RAD_W-1:0] sq_rad [0:SQRT_STEPS];
  logic [REM_W-1:0] sq_rem [0:SQRT_STEPS];
  logic [ROOT_W-1:0] sq_root [0:SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= SQRT_STEPS; k++) begin
        sq_line[k].valid <= 1'b0;
      end
    end else if (en) begin
      sq_line[0] <= cls;
      for (int k = 1; k <= SQRT_STEPS; k++) begin
        sq_line[k] <= sq_line[k-1];
      end
    end
    if (en) begin
      st2_rad <= cls_rad;
    end
  end

  assign sq_rad[0] = st2_rad;
  assign sq_rem[0] = '0;
  assign sq_root[0] = '0;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    qrs_sqrt_cell u_cell (
      .clk(clk), .en(en),
      .rad_i(sq_rad[k]), .rem_i(sq_rem[k]), .root_i(sq_root[k]),
      .rad_o(sq_rad[k+1]), .rem_o(sq_rem[k+1]), .root_o(sq_root[k+1])
    );
  end

  // Merge: form both numerators, split into sign and magnitude.
  sq_side_t sq_end;
  logic signed [DISC_W-1:0] sx, n1, n2;
  dv_side_t mrg;
  logic [NUM_W-1:0] n1_mag, n2_mag;

  always_comb begin
    sq_end = sq_line[SQRT_STEPS];
    sx = sq_end.use_s ? $signed({3'b000, sq_root[SQRT_STEPS]}) : '0;
    n1 = DISC_W'(sq_end.nbase) + sx;
    n2 = DISC_W'(sq_end.nbase) - sx;
    n1_mag = n1[DISC_W-1] ? NUM_W'(-n1) : n1[NUM_W-1:0];
    n2_mag = n2[DISC_W-1] ? NUM_W'(-n2) : n2[NUM_W-1:0];
    mrg.valid = sq_end.valid;
    mrg.kind = sq_end.kind;
    mrg.div_en = sq_end.div_en;
    mrg.neg1 = n1[DISC_W-1] ^ sq_end.dv[COEF_W-1];
    mrg.neg2 = n2[DISC_W-1] ^ sq_end.dv[COEF_W-1];
    mrg.dmag = sq_end.dv[COEF_W-1] ? DVR_W'(-sq_end.dv) : DVR_W'(sq_end.dv);
  end

  // Divider rows, one per root, sharing the divisor in the sideband.
  dv_side_t dv_line [0:DIV_STEPS];
  logic [NUM_W-1:0] m_n1, m_n2;
  logic [DVR_W-1:0] d1_rem [0:DIV_STEPS];
  logic [DVR_W-1:0] d2_rem [0:DIV_STEPS];
  logic [NUM_W-1:0] d1_nq [0:DIV_STEPS];
  logic [NUM_W-1:0] d2_nq [0:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DIV_STEPS; k++) begin
        dv_line[k].valid <= 1'b0;
      end
    end else if (en) begin
      dv_line[0] <= mrg;
      for (int k = 1; k <= DIV_STEPS; k++) begin
        dv_line[k] <= dv_line[k-1];
      end
    end
    if (en) begin
      m_n1 <= n1_mag;
      m_n2 <= n2_mag;
    end
  end

  assign d1_rem[0] = '0;
  assign d2_rem[0] = '0;
  assign d1_nq[0] = m_n1;
  assign d2_nq[0] = m_n2;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    qrs_div_cell u_lane1 (
      .clk(clk), .en(en), .dmag(dv_line[k].dmag),
      .rem_i(d1_rem[k]), .nq_i(d1_nq[k]), .rem_o(d1_rem[k+1]), .nq_o(d1_nq[k+1])
    );
    qrs_div_cell u_lane2 (
      .clk(clk), .en(en), .dmag(dv_line[k].dmag),
      .rem_i(d2_rem[k]), .nq_i(d2_nq[k]), .rem_o(d2_rem[k+1]), .nq_o(d2_nq[k+1])
    );
  end

  // Sign restore and clamp to the Q16.16 range.
  function automatic logic [ROOT_W:0] clamp_root(input logic [NUM_W-1:0] q, input logic neg);
    logic sat;
    logic [ROOT_W-1:0] v;
    if (neg) begin
      sat = (q > NUM_W'(34'h080000000));
      v = sat ? 32'h80000000 : (~q[ROOT_W-1:0] + 32'd1);
    end else begin
      sat = (q > NUM_W'(34'h07FFFFFFF));
      v = sat ? 32'h7FFFFFFF : q[ROOT_W-1:0];
    end
    return {sat, v};
  endfunction

  dv_side_t dv_end;
  logic [ROOT_W:0] c1, c2;
  res_t res;

  always_comb begin
    dv_end = dv_line[DIV_STEPS];
    c1 = clamp_root(d1_nq[DIV_STEPS], dv_end.neg1);
    c2 = clamp_root(d2_nq[DIV_STEPS], dv_end.neg2);
    res.kind = dv_end.kind;
    res.r1 = '0;
    res.r2 = '0;
    res.sat = 1'b0;
    if (dv_end.div_en) begin
      res.r1 = c1[ROOT_W-1:0];
      if (dv_end.kind == KIND_TWO) begin
        res.r2 = c2[ROOT_W-1:0];
        res.sat = c1[ROOT_W] | c2[ROOT_W];
      end else begin
        res.r2 = c1[ROOT_W-1:0];
        res.sat = c1[ROOT_W];
      end
    end
  end

  // Output register with a one-item skid behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (!out_valid || result.ready) begin
        out_r <= skid;
        out_valid <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (out_valid && !result.ready) begin
      if (dv_end.valid) begin
        skid <= res;
        skid_valid <= 1'b1;
      end
    end else begin
      out_valid <= dv_end.valid;
      out_r <= res;
    end
  end

  assign result.valid = out_valid;
  assign result.solution_kind = out_r.kind;
  assign result.root_one = out_r.r1;
  assign result.root_two = out_r.r2;
  assign result.saturated = out_r.sat;

  // No roots and no clamp flag unless a root exists.
  a_empty_kinds: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.solution_kind == KIND_NONE ||
                     result.solution_kind == KIND_UNLIMITED)
    |-> result.root_one == '0 && result.root_two == '0 && !result.saturated)
    else $error("roots present for a kind without roots");

  // A single root is reported twice.
  a_single_same: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.solution_kind == KIND_SINGLE |-> result.root_one == result.root_two)
    else $error("single root differs between the two root fields");

  // The skid only holds an item while the output register is occupied.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds an item while the output is empty");

  // A held skid item is not dropped while the receiver stalls.
  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !result.ready |=> skid_valid && $stable(skid))
    else $error("skid item lost during a stall");

endmodule

[verif/qrs_tb_if.sv]
`timescale 1ns / 100ps
// Note for the testbench: the channel interfaces come from the RTL (qrs_coef_if,
// qrs_result_if) and are instantiated directly; this file holds the coef_set_t package.
// Depends on qrs_pkg.
package qrs_tb_pkg;
  import qrs_pkg::*;
  typedef struct packed {
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    logic signed [COEF_W-1:0] c;
  } coef_set_t;
endpackage

[verif/tb_quadratic_root_solver_unit.sv]
`timescale 1ns / 100ps
// Testbench for quadratic_root_solver_unit: drives coefficient sets, predicts the
// kind, roots and clamp flag of each, and compares results in order.
// Depends on qrs_pkg, qrs_tb_pkg, qrs_coef_if, qrs_result_if and the RTL.
module tb_quadratic_root_solver_unit;
  import qrs_pkg::*;
  import qrs_tb_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  qrs_coef_if coef ();
  qrs_result_if result ();

  quadratic_root_solver_unit dut (
    .clk(clk),
    .rst(rst),
    .coef(coef),
    .result(result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  coef_set_t pending_sets[$];
  res_t expected_roots[$];
  int mismatches = 0;
  int unexpected = 0;
  bit stim_done = 1'b0;
  // Set once the run enters its last part, where neither side idles.
  bit calm = 1'b0;
  // Counted down by the receiver for the long hold-off.
  int holdoff_left = 0;
  // High after a rising edge at which the offered item was accepted.
  bit in_taken = 1'b0;

  // Integer square root of a 64 bit value, digit by digit.
  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v = v - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  // Clamp to the Q16.16 range and note whether clamping happened.
  function automatic logic signed [31:0] clamp_q16(longint v, inout logic sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Classify the real solutions of a*x^2 + b*x + c = 0. SystemVerilog
  // division of longints truncates toward zero, as the roots require.
  function automatic res_t solve_quadratic(coef_set_t cs);
    res_t r;
    longint a;
    longint b;
    longint c;
    longint d;
    longint s;
    longint nb;
    logic sat;
    a = cs.a;
    b = cs.b;
    c = cs.c;
    sat = 1'b0;
    r.kind = KIND_NONE;
    r.r1 = '0;
    r.r2 = '0;
    if (a == 0) begin
      if (b == 0) begin
        r.kind = (c == 0) ? KIND_UNLIMITED : KIND_NONE;
      end else begin
        r.kind = KIND_SINGLE;
        r.r1 = clamp_q16((-c * 65536) / b, sat);
        r.r2 = r.r1;
      end
    end else begin
      d = b * b - 4 * a * c;
      if (d == 0) begin
        r.kind = KIND_SINGLE;
        r.r1 = clamp_q16((-b * 32768) / a, sat);
        r.r2 = r.r1;
      end else if (d > 0) begin
        s = isqrt64(64'(d) << 30);
        nb = -b * 32768;
        r.kind = KIND_TWO;
        r.r1 = clamp_q16((nb + s) / a, sat);
        r.r2 = clamp_q16((nb - s) / a, sat);
      end
    end
    r.sat = sat;
    return r;
  endfunction

  function automatic coef_set_t mk(int a, int b, int c);
    coef_set_t cs;
    cs.a = a[15:0];
    cs.b = b[15:0];
    cs.c = c[15:0];
    return cs;
  endfunction

  // Random coefficient: half small magnitudes so roots stay in range, with
  // full-range values and extremes mixed in.
  function automatic logic [15:0] rand_coef();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'h8000;
      2: return 16'h7fff;
      3, 4: return 16'($urandom_range(0, 65535));
      5, 6: return 16'($signed($urandom_range(0, 511)) - 256);
      default: return 16'($signed($urandom_range(0, 8191)) - 4096);
    endcase
  endfunction

  // Driver: takes the next pending item, idles in random bursts, and holds
  // valid and data steady until the item is accepted.
  int send_gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      coef.valid <= 1'b0;
    end else if (coef.valid && !in_taken) begin
      // Keep offering the same item.
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      coef.valid <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      send_gap <= $urandom_range(0, 9);
      coef.valid <= 1'b0;
    end else if (pending_sets.size() > 0) begin
      coef_set_t cs;
      cs = pending_sets.pop_front();
      coef.valid <= 1'b1;
      coef.coef_quad <= cs.a;
      coef.coef_lin <= cs.b;
      coef.coef_const <= cs.c;
    end else begin
      coef.valid <= 1'b0;
    end
  end

  // Predict at acceptance, so the queue order follows the handshake.
  always @(posedge clk) begin
    in_taken <= !rst && coef.valid && coef.ready;
    if (!rst && coef.valid && coef.ready) begin
      coef_set_t cs;
      cs.a = coef.coef_quad;
      cs.b = coef.coef_lin;
      cs.c = coef.coef_const;
      expected_roots.push_back(solve_quadratic(cs));
    end
  end

  // Receiver ready: random stall bursts, plus one long hold-off on request.
  int stall_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else if (holdoff_left > 0) begin
      holdoff_left <= holdoff_left - 1;
      result.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      result.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 9);
      result.ready <= 1'b0;
    end else begin
      result.ready <= 1'b1;
    end
  end

  // Monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && result.valid && result.ready) begin
      if (expected_roots.size() == 0) begin
        unexpected++;
        mismatches++;
        if (mismatches <= 10)
          $display("Result with no item waiting: kind %0d", result.solution_kind);
      end else begin
        res_t e;
        e = expected_roots.pop_front();
        if (result.solution_kind !== e.kind || result.root_one !== e.r1 ||
            result.root_two !== e.r2 || result.saturated !== e.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected kind %0d r1 %h r2 %h sat %0b, got %0d %h %h %0b",
                     e.kind, e.r1, e.r2, e.sat, result.solution_kind,
                     result.root_one, result.root_two, result.saturated);
        end
      end
    end
  end

  initial begin
    int a;
    int b;
    int c;
    int k;
    coef.valid = 1'b0;
    coef.coef_quad = '0;
    coef.coef_lin = '0;
    coef.coef_const = '0;
    result.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: linear cases, unlimited, none, double roots with both signs
    // of a, b zero, c zero, extremes and clamping.
    pending_sets.push_back(mk(0, 0, 0));
    pending_sets.push_back(mk(0, 0, 5));
    pending_sets.push_back(mk(0, 256, -512));
    pending_sets.push_back(mk(0, 1, -32768));
    pending_sets.push_back(mk(0, -1, 32767));
    pending_sets.push_back(mk(0, -32768, -32768));
    pending_sets.push_back(mk(256, -512, 256));
    pending_sets.push_back(mk(-256, 512, -256));
    pending_sets.push_back(mk(1, 0, -1));
    pending_sets.push_back(mk(-1, 0, 1));
    pending_sets.push_back(mk(256, 0, 0));
    pending_sets.push_back(mk(256, 768, 0));
    pending_sets.push_back(mk(256, 0, 256));
    pending_sets.push_back(mk(1, -32768, 0));
    pending_sets.push_back(mk(1, 32767, -32768));
    pending_sets.push_back(mk(-32768, -32768, -32768));
    pending_sets.push_back(mk(32767, 32767, 32767));
    pending_sets.push_back(mk(-32768, 32767, 32767));
    pending_sets.push_back(mk(32767, -32768, -32768));
    pending_sets.push_back(mk(1, 2, 1));
    pending_sets.push_back(mk(-1, -2, -1));
    pending_sets.push_back(mk(4, -4, 1));

    // Random: a third are built with a zero discriminant (a=k^2 style
    // factors: a=p*p, b=2*p*q, c=q*q) or a zero a, to reach single roots.
    // Factors stay small enough that 2*p*q fits the coefficient width.
    for (int i = 0; i < 1300; i++) begin
      k = $urandom_range(0, 5);
      if (k == 0) begin
        a = $signed($urandom_range(0, 180)) - 90;
        b = $signed($urandom_range(0, 180)) - 90;
        if (a == 0) a = 1;
        pending_sets.push_back(mk(a * a * (($urandom_range(0, 1) != 0) ? 1 : -1),
                                  0, 0));
        c = pending_sets[$].a;
        pending_sets[$] = mk(c, 2 * a * b * ((c < 0) ? -1 : 1),
                             b * b * ((c < 0) ? -1 : 1));
      end else if (k == 1) begin
        pending_sets.push_back(mk(0, $signed(rand_coef()), $signed(rand_coef())));
      end else begin
        pending_sets.push_back(mk($signed(rand_coef()), $signed(rand_coef()),
                                  $signed(rand_coef())));
      end
      if (i == 400) begin
        // Long receiver hold-off while the sender keeps offering items.
        wait (pending_sets.size() < 300);
        holdoff_left = 200;
      end
    end
    // The last couple of hundred items run with neither side idling.
    wait (pending_sets.size() < 200);
    calm = 1'b1;
    wait (pending_sets.size() == 0 && !coef.valid);
    wait (expected_roots.size() == 0);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_roots.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

[quadratic_root_solver_unit.f]
src/qrs_pkg.sv
src/qrs_coef_if.sv
src/qrs_result_if.sv
src/qrs_sqrt_cell.sv
src/qrs_div_cell.sv
src/quadratic_root_solver_unit.sv
verif/qrs_tb_if.sv
verif/tb_quadratic_root_solver_unit.sv
